>>> design/ukol_pkg.sv
// Package for the unique-key ordered list: sizes, operation codes, the
// sequencer state type and the result record. No dependencies.
package ukol_pkg;

  localparam int DEPTH   = 32;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int CODE_W  = 31;
  localparam int OP_W    = 3;
  localparam int TOTAL_W = 6;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT     = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP,
    ST_DUMP
  } state_e;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] item_code;
    logic              item_valid;
    logic [TOTAL_W-1:0] entry_total;
    logic              last;
  } res_t;

endpackage

>>> design/ukol_if.sv
// Valid/ready channel interfaces for requests and results of the ordered list.
// Depends on ukol_pkg for field widths.
interface ukol_req_if import ukol_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [31:0]       code;

  modport source (output valid, op, code, input ready);
  modport sink   (input valid, op, code, output ready);
endinterface

interface ukol_rsp_if import ukol_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [CODE_W-1:0]        item_code;
  logic                     item_valid;
  logic [TOTAL_W-1:0]       entry_total;
  logic                     last;

  modport source (output valid, ok, item_code, item_valid, entry_total, last,
                  input ready);
  modport sink   (input valid, ok, item_code, item_valid, entry_total, last,
                  output ready);
endinterface

>>> design/ukol_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read and write of the same address in one cycle returns the old data.
module ukol_ram #(
  parameter int DATA_W  = 31,
  parameter int DEPTH_N = 32
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH_N)-1:0]  waddr_i,
  input  logic [DATA_W-1:0]           wdata_i,
  input  logic [$clog2(DEPTH_N)-1:0]  raddr_i,
  output logic [DATA_W-1:0]           rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH_N];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> design/ukol_ctrl.sv
// Sequencer of the ordered list: walks the entry RAM one slot per cycle with
// a single comparator, compacts on remove and streams entries on dump.
// Depends on ukol_pkg; drives ukol_ram.
module ukol_ctrl import ukol_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic [OP_W-1:0]    req_op_i,
  input  logic [31:0]        req_code_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [CODE_W-1:0]  ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [CODE_W-1:0]  ram_rdata_i
);

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      head_q, head_d;
  logic               ok_q, ok_d;
  logic [AW-1:0]      head_dec;
  logic               code_pos;
  logic               dump_last;

  // Logical position to RAM slot in the circular buffer.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {1'b0, pos} + (CW+1)'(head);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign code_pos  = (req_code_i[31] == 1'b0) && (req_code_i != '0);
  assign dump_last = (idx_q == CW'(count_q - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    code_q <= code_d;
    idx_q  <= idx_d;
    ok_q   <= ok_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    code_d      = code_q;
    idx_d       = idx_q;
    count_d     = count_q;
    head_d      = head_q;
    ok_d        = ok_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.entry_total = TOTAL_W'(count_q);
    res_o.last  = 1'b1;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot(head_q, count_q);
    ram_wdata_o = code_q;

    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d   = req_op_i;
          code_d = req_code_i[CODE_W-1:0];
          idx_d  = '0;
          ok_d   = 1'b0;
          case (req_op_i)
            OP_INS_FRONT, OP_INS_BACK: begin
              state_d = (code_pos && count_q < CW'(DEPTH)) ? ST_SCAN : ST_RESP;
            end
            OP_REMOVE, OP_SEARCH: begin
              state_d = code_pos ? ST_SCAN : ST_RESP;
            end
            OP_DUMP: begin
              state_d = (count_q == '0) ? ST_RESP : ST_DUMP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (idx_q == count_q) begin
          // Code not held.
          state_d = ST_RESP;
          case (op_q)
            OP_INS_FRONT: begin
              ram_we_o    = 1'b1;
              ram_waddr_o = head_dec;
              head_d      = head_dec;
              count_d     = count_q + 1'b1;
              ok_d        = 1'b1;
            end
            OP_INS_BACK: begin
              ram_we_o    = 1'b1;
              count_d     = count_q + 1'b1;
              ok_d        = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end else if (ram_rdata_i == code_q) begin
          case (op_q)
            OP_REMOVE: begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_SHIFT;
            end
            OP_SEARCH: begin
              ok_d    = 1'b1;
              state_d = ST_RESP;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = ST_RESP;
            end
          endcase
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_SHIFT: begin
        if (idx_q == count_q) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = slot(head_q, idx_q - 1'b1);
          ram_wdata_o = ram_rdata_i;
          idx_d       = idx_q + 1'b1;
        end
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        res_o.ok    = ok_q;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_DUMP: begin
        res_valid_o      = 1'b1;
        res_o.item_code  = ram_rdata_i;
        res_o.item_valid = 1'b1;
        res_o.last       = dump_last;
        if (res_ready_i) begin
          if (dump_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The read port always follows the next index, so the registered read
    // data holds the entry at the current index.
    ram_raddr_o = slot(head_d, idx_d);
  end

endmodule

>>> design/unique_key_ordered_list_top.sv
// Ordered list of up to DEPTH distinct positive codes; one request per transfer.
// Insert, search and remove scan the entries from the front; remove then moves each entry
// behind the match one slot forward; a dump gives one result per cycle while taken.
// The next request is taken in the cycle after the last result leaves the sequencer.
// Reset (rst_ni low, asynchronous) empties the list; the entry RAM is not cleared.
// Depends on ukol_pkg, ukol_if, ukol_ram and ukol_ctrl.
module unique_key_ordered_list_top import ukol_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ukol_req_if.sink   req_i,
  ukol_rsp_if.source rsp_o
);

  // Sequencer to output register.
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // Sequencer to entry RAM.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  // Output register: holds one result so that the sequencer can move on while
  // the consumer has not yet taken the previous transfer.
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  // The entries live in a circular buffer: a front insert only moves the head
  // back by one slot, so no insert ever has to move existing entries.
  ukol_ram #(
    .DATA_W  (CODE_W),
    .DEPTH_N (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The sequencer walks the list with one comparator, one slot per cycle.
  ukol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.op),
    .req_code_i  (req_i.code),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // A new result may load when the register is empty or is being emptied in
  // this same cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_q.ok;
  assign rsp_o.item_code   = out_q.item_code;
  assign rsp_o.item_valid  = out_q.item_valid;
  assign rsp_o.entry_total = out_q.entry_total;
  assign rsp_o.last        = out_q.last;

endmodule
